/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the word-sum checksum RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high.
`define BWS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bws assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst is high.
`define BWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bws assertion failed");

`endif

/* rtl/bws_pkg.sv */
// ---------------------------------------------------------------------------
// bws_pkg
// Types and constants shared by the word-sum checksum modules.
// ---------------------------------------------------------------------------
package bws_pkg;

  localparam int WORD_W            = 64;
  localparam int BYTE_W            = 8;
  localparam int NUM_LANES         = 4;
  localparam int MAX_LANES_DEFAULT = 4;
  localparam int CFG_INDEX_W       = 3;

  // Checksum size codes held in width_mode.
  localparam logic [1:0] MODE_32  = 2'd0;
  localparam logic [1:0] MODE_64  = 2'd1;
  localparam logic [1:0] MODE_128 = 2'd2;
  localparam logic [1:0] MODE_256 = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LANE0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LANE1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LANE2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LANE3 = 3'd4;

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] lane_vec_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_payload_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum_lane0;
    logic [WORD_W-1:0] sum_lane1;
    logic [WORD_W-1:0] sum_lane2;
    logic [WORD_W-1:0] sum_lane3;
  } out_payload_t;

  // Word event handed from the byte packer to the lane accumulators.
  typedef struct packed {
    logic              start;  // byte opens a new message
    logic              done;   // word is complete or final, add it
    logic              last;   // byte closes the message
    logic [WORD_W-1:0] word;
  } word_evt_t;

endpackage

/* rtl/bws_stream_if.sv */
// ---------------------------------------------------------------------------
// bws_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface bws_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/bws_packer.sv */
// ---------------------------------------------------------------------------
// bws_packer
// Packs message bytes big-endian into 32- or 64-bit words.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bws_packer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      narrow,
  input  logic [bws_pkg::BYTE_W-1:0] data_byte,
  input  logic                      last_byte,
  output bws_pkg::word_evt_t        evt
);

  logic [bws_pkg::WORD_W-1:0] word_buffer;
  logic [bws_pkg::WORD_W-1:0] word_buffer_next;
  logic [2:0]                 byte_position;
  logic [2:0]                 byte_position_next;
  logic                       in_message;
  logic                       in_message_next;

  logic [bws_pkg::WORD_W-1:0] buf_base;
  logic [2:0]                 slot;
  logic [2:0]                 byte_idx;
  logic [bws_pkg::WORD_W-1:0] byte_shifted;

  always_comb begin
    evt.start = !in_message;
    buf_base  = evt.start ? '0 : word_buffer;
    slot      = evt.start ? 3'd0 : byte_position;
    if (narrow) begin
      slot     = {1'b0, slot[1:0]};
      byte_idx = {1'b0, 2'd3 - slot[1:0]};
    end else begin
      byte_idx = 3'd7 - slot;
    end
    byte_shifted = bws_pkg::WORD_W'(data_byte) << {byte_idx, 3'b000};
    evt.word     = buf_base | byte_shifted;
    evt.last     = last_byte;
    evt.done     = last_byte || (narrow ? (slot == 3'd3) : (slot == 3'd7));

    if (evt.done) begin
      word_buffer_next   = '0;
      byte_position_next = 3'd0;
    end else begin
      word_buffer_next   = evt.word;
      byte_position_next = slot + 3'd1;
    end
    in_message_next = !last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      in_message    <= 1'b0;
    end else if (fire) begin
      byte_position <= byte_position_next;
      in_message    <= in_message_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      word_buffer <= word_buffer_next;
    end
  end

  `BWS_ASSERT_NEXT(a_word_done_clears_slot, fire && evt.done, byte_position == 3'd0)
  `BWS_ASSERT_NEXT(a_last_ends_message, fire && evt.last, !in_message)
  `BWS_ASSERT_SAME(a_narrow_slot_range, fire && narrow, slot[2] == 1'b0)

endmodule

/* rtl/bws_lanes.sv */
// ---------------------------------------------------------------------------
// bws_lanes
// Lane accumulators with round-robin lane selection and seed loading.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bws_lanes #(
  parameter int MAX_LANES = bws_pkg::MAX_LANES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [1:0]            width_mode,
  input  bws_pkg::lane_vec_t    seeds,
  input  bws_pkg::word_evt_t    evt,
  output bws_pkg::out_payload_t result
);

  localparam logic [2:0] LaneCap = 3'(MAX_LANES);

  bws_pkg::lane_vec_t         lane_acc;
  bws_pkg::lane_vec_t         lane_acc_next;
  bws_pkg::lane_vec_t         acc_base;
  logic [1:0]                 lane_ptr;
  logic [1:0]                 lane_ptr_next;
  logic [1:0]                 ptr_base;
  logic [1:0]                 ptr_eff;
  logic [2:0]                 lanes_mode;
  logic [2:0]                 lanes;
  logic                       narrow;
  logic [bws_pkg::WORD_W-1:0] lane_sum;

  always_comb begin
    narrow = (width_mode == bws_pkg::MODE_32);
    case (width_mode)
      bws_pkg::MODE_256: lanes_mode = 3'd4;
      bws_pkg::MODE_128: lanes_mode = 3'd2;
      default:           lanes_mode = 3'd1;
    endcase
    lanes = (lanes_mode < LaneCap) ? lanes_mode : LaneCap;

    acc_base = evt.start ? seeds : lane_acc;
    if (evt.start && narrow) begin
      acc_base[0][63:32] = '0;
    end
    ptr_base = evt.start ? 2'd0 : lane_ptr;
    ptr_eff  = ({1'b0, ptr_base} < lanes) ? ptr_base : 2'd0;

    lane_sum = acc_base[ptr_eff] + evt.word;
    if (narrow) begin
      lane_sum[63:32] = '0;
    end

    lane_acc_next = acc_base;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (evt.done && (ptr_eff == 2'(i))) begin
        lane_acc_next[i] = lane_sum;
      end
    end

    if (evt.last) begin
      lane_ptr_next = 2'd0;
    end else if (evt.done) begin
      lane_ptr_next = ((3'(ptr_eff) + 3'd1) >= lanes) ? 2'd0 : ptr_eff + 2'd1;
    end else begin
      lane_ptr_next = ptr_base;
    end

    result.sum_lane0 = lane_acc_next[0];
    if (narrow) begin
      result.sum_lane0[63:32] = '0;
    end
    result.sum_lane1 = lane_acc_next[1];
    result.sum_lane2 = lane_acc_next[2];
    result.sum_lane3 = lane_acc_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_ptr <= 2'd0;
    end else if (fire) begin
      lane_ptr <= lane_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lane_acc <= lane_acc_next;
    end
  end

  `BWS_ASSERT_NEXT(a_last_resets_pointer, fire && evt.last, lane_ptr == 2'd0)
  `BWS_ASSERT_SAME(a_pointer_within_lanes, fire, {1'b0, ptr_eff} < lanes)

endmodule

/* rtl/be_word_sum_checksum_unit.sv */
// ---------------------------------------------------------------------------
// be_word_sum_checksum_unit
// Additive big-endian word-sum checksum over a byte stream, up to four lanes.
// ---------------------------------------------------------------------------
//
//   channel   | role | one transfer carries
//   ----------+------+-----------------------------------------------
//   byte_in   | sink | data_byte, last_byte (one message byte)
//   sum_out   | src  | sum_lane0 .. sum_lane3 (one result per message)
//   cfg_*     | sink | register write, no handshake
//
// One byte is taken per cycle, sustained, unless a last byte is held back while
// the result register is full and not drained. A byte is folded into the running
// word and the lane sums while it sits in the input register, and the result
// register loads the lane sums as the last byte leaves the input register.
// Reset (rst, synchronous) empties both registers, clears the byte and lane
// counters, and returns the configuration registers to zero. A stalled
// result holds the output register; bytes that complete no message still
// pass, and a last byte waits in the input register until the result slot
// frees up.
//
// Each byte is packed big-endian into a 32-bit word (mode 0) or a 64-bit
// word (other modes). When a word fills, or on the last byte of a message,
// the word is added into the current lane and the lane pointer moves on
// round-robin. The first byte of a message loads the lanes from the seeds.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module be_word_sum_checksum_unit #(
  parameter int MAX_LANES = bws_pkg::MAX_LANES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  bws_stream_if.sink                      byte_in,
  bws_stream_if.source                    sum_out,
  input  logic                            cfg_write_en,
  input  logic [bws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bws_pkg::WORD_W-1:0]      cfg_wdata
);

  // Configuration registers.
  logic [1:0]         width_mode;
  bws_pkg::lane_vec_t seeds;

  // Input register.
  logic                        in_valid;
  logic [bws_pkg::BYTE_W-1:0]  in_byte;
  logic                        in_last;

  // Result register.
  logic                  out_valid;
  bws_pkg::out_payload_t out_data;

  logic                  advance;
  logic                  fire;
  logic                  narrow;
  bws_pkg::word_evt_t    evt;
  bws_pkg::out_payload_t lane_result;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= bws_pkg::MODE_32;
      seeds      <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bws_pkg::REG_WIDTH_MODE: width_mode <= cfg_wdata[1:0];
        bws_pkg::REG_SEED_LANE0: seeds[0]   <= cfg_wdata;
        bws_pkg::REG_SEED_LANE1: seeds[1]   <= cfg_wdata;
        bws_pkg::REG_SEED_LANE2: seeds[2]   <= cfg_wdata;
        bws_pkg::REG_SEED_LANE3: seeds[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The byte in the input register moves on unless it is a last byte and
  // the result register is still full and not being drained this cycle.
  assign advance       = !in_last || !out_valid || sum_out.ready;
  assign fire          = in_valid && advance;
  assign byte_in.ready = !in_valid || advance;
  assign narrow        = (width_mode == bws_pkg::MODE_32);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.payload.data_byte;
      in_last <= byte_in.payload.last_byte;
    end
  end

  bws_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .narrow    (narrow),
    .data_byte (in_byte),
    .last_byte (in_last),
    .evt       (evt)
  );

  bws_lanes #(
    .MAX_LANES (MAX_LANES)
  ) u_lanes (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .width_mode (width_mode),
    .seeds      (seeds),
    .evt        (evt),
    .result     (lane_result)
  );

  // The result register fills on a last byte and empties on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_last) begin
      out_valid <= 1'b1;
    end else if (sum_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      out_data <= lane_result;
    end
  end

  assign sum_out.valid   = out_valid;
  assign sum_out.payload = out_data;

  `BWS_ASSERT_NEXT(a_last_makes_result, fire && in_last, out_valid)
  `BWS_ASSERT_SAME(a_no_result_overwrite, out_valid && !sum_out.ready && fire, !in_last)
  `BWS_ASSERT_SAME(a_full_input_blocks, in_valid && !advance, !byte_in.ready)

endmodule
